// ===== sv/wtt_pkg.sv =====
// Package for the windowed time trigger: widths, codes, register indexes,
// payload structs and the divider request struct. No dependencies.
`timescale 1ns / 1ps

package wtt_pkg;

  localparam int unsigned TIME_BITS     = 48;
  localparam int unsigned SAMPLE_BITS   = 16;
  localparam int unsigned TICK_BITS     = 32;
  localparam int unsigned PROG_BITS     = 16;
  localparam int unsigned PROG_FRAC     = 14;
  localparam int unsigned DIV_CNT_BITS  = $clog2(PROG_FRAC);
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 32;
  localparam int unsigned MODE_BITS     = 2;
  localparam int unsigned FLAG_BITS     = 3;

  // Progress of 1.0 in Q2.14 and the code that marks an inactive phase (-1.0).
  localparam logic [PROG_BITS-1:0] PROG_ONE  = PROG_BITS'(1) << PROG_FRAC;
  localparam logic [PROG_BITS-1:0] PROG_IDLE = ~PROG_ONE + 1'b1;

  // Bit positions in mode_flags.
  localparam int unsigned FLAG_ENABLE  = 0;
  localparam int unsigned FLAG_LATCHED = 1;
  localparam int unsigned FLAG_REPEAT  = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_LOW_THRESHOLD  = 3'd0,
    REG_HIGH_THRESHOLD = 3'd1,
    REG_UP_TICKS       = 3'd2,
    REG_DOWN_TICKS     = 3'd3,
    REG_COUNT_MODE     = 3'd4,
    REG_SENSE_MODE     = 3'd5,
    REG_MODE_FLAGS     = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CLS_UNKNOWN = 2'd0,
    CLS_BELOW   = 2'd1,
    CLS_INSIDE  = 2'd2,
    CLS_ABOVE   = 2'd3
  } class_e;

  typedef enum logic [MODE_BITS-1:0] {
    CNT_UP      = 2'd0,
    CNT_DOWN    = 2'd1,
    CNT_UP_DOWN = 2'd2
  } count_mode_e;

  typedef enum logic [MODE_BITS-1:0] {
    SENSE_ABOVE  = 2'd0,
    SENSE_BELOW  = 2'd1,
    SENSE_INSIDE = 2'd2
  } sense_mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_COMMIT
  } state_e;

  typedef enum logic [1:0] {
    ACT_HOLD,
    ACT_ARM,
    ACT_FAIL,
    ACT_COUNT
  } action_e;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_value;
    logic [TIME_BITS-1:0]          time_now;
  } wtt_in_t;

  typedef struct packed {
    logic                        done_level;
    logic signed [PROG_BITS-1:0] forward_progress;
    logic signed [PROG_BITS-1:0] reverse_progress;
    logic                        forward_failed;
    logic                        reverse_failed;
    logic                        outputs_changed;
  } wtt_out_t;

  typedef struct packed {
    logic                 start;
    logic [TICK_BITS-1:0] dividend;
    logic [TICK_BITS-1:0] divisor;
  } div_req_t;

endpackage

// ===== sv/wtt_div.sv =====
// Restoring divider for the progress fraction: quotient of dividend * 2^14
// by divisor, one quotient bit per cycle. Depends on wtt_pkg.
`timescale 1ns / 1ps

module wtt_div import wtt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  div_req_t             req_i,
  output logic                 done_o,
  output logic [PROG_FRAC-1:0] quo_o
);

  logic [TICK_BITS-1:0]    rem_q, dsr_q;
  logic [PROG_FRAC-1:0]    quo_q;
  logic [DIV_CNT_BITS-1:0] cnt_q;
  logic                    busy_q, done_q;

  logic [TICK_BITS:0]   rem_sh;
  logic [TICK_BITS+1:0] diff;
  logic                 take;

  // The dividend is always below the divisor, so the remainder fits in
  // TICK_BITS bits and the shifted remainder in one bit more.
  assign rem_sh = {rem_q, 1'b0};
  assign diff   = {1'b0, rem_sh} - {2'b00, dsr_q};
  assign take   = ~diff[TICK_BITS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_BITS'(PROG_FRAC - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= take ? diff[TICK_BITS-1:0] : rem_sh[TICK_BITS-1:0];
      quo_q <= {quo_q[PROG_FRAC-2:0], take};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== sv/windowed_time_trigger.sv =====
// Channel   Direction  Handshake            Payload
// in        input      in_valid_i/in_stall_o   wtt_in_t (sample, time)
// out       output     out_valid_o/out_stall_i wtt_out_t (done, progress, flags)
// cfg       input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// An item passes capture, evaluate and commit when no division is needed,
// and capture, evaluate, division and commit while a phase is counting and
// not yet full; the 14-step restoring divider forms the Q2.14 progress.
// Reset clears the configuration to its defaults and disarms the timer.
// in_stall_o is high while an item is in work; the finished result waits in
// the output register, and the commit of the next item waits while it is full.
// Depends on wtt_pkg and wtt_div.
`timescale 1ns / 1ps

module windowed_time_trigger import wtt_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  wtt_in_t                  in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output wtt_out_t                 out_data_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  // Configuration registers.
  logic signed [SAMPLE_BITS-1:0] lo_q, hi_q;
  logic [TICK_BITS-1:0]          up_q, dn_q;
  logic [MODE_BITS-1:0]          cmode_q, smode_q;
  logic [FLAG_BITS-1:0]          flags_q;

  // Trigger state.
  state_e                        state_q, state_d;
  action_e                       act_q, eval_act;
  logic [1:0]                    class_q;
  logic                          armed_q, halted_q, down_q;
  logic [TIME_BITS-1:0]          start_q, deadline_q;
  logic                          o_done_q, o_ff_q, o_rf_q;
  logic [PROG_BITS-1:0]          o_fp_q, o_rp_q;
  logic                          prev_valid_q;
  logic                          p_done_q, p_ff_q, p_rf_q;
  logic [PROG_BITS-1:0]          p_fp_q, p_rp_q;

  // Item under work and output register.
  logic signed [SAMPLE_BITS-1:0] smp_q;
  logic [TIME_BITS-1:0]          now_q;
  logic [PROG_BITS-1:0]          prog_q;
  wtt_out_t                      out_q;
  logic                          out_valid_q;

  logic in_fire, cfg_fire, out_free;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------------
  // Evaluation of the captured item.
  logic [1:0]           cls;
  logic                 hit, class_upd;
  logic [MODE_BITS-1:0] mode;
  logic [TIME_BITS-1:0] el;
  logic [TICK_BITS-1:0] run_ticks;
  logic                 el_full;

  always_comb begin
    if (smp_q < lo_q) begin
      cls = CLS_BELOW;
    end else if (smp_q < hi_q) begin
      cls = CLS_INSIDE;
    end else begin
      cls = CLS_ABOVE;
    end

    case (smode_q)
      SENSE_ABOVE:  hit = (cls == CLS_ABOVE);
      SENSE_BELOW:  hit = (cls == CLS_BELOW);
      SENSE_INSIDE: hit = (cls == CLS_INSIDE);
      default:      hit = 1'b0;
    endcase

    // The unused count mode behaves as a plain up count.
    mode = (cmode_q == CNT_DOWN || cmode_q == CNT_UP_DOWN) ? cmode_q : CNT_UP;

    class_upd = 1'b1;
    if (!flags_q[FLAG_ENABLE] || halted_q) begin
      eval_act  = ACT_HOLD;
      class_upd = 1'b0;
    end else if (class_q == CLS_UNKNOWN) begin
      eval_act = ACT_HOLD;
    end else if (!armed_q && hit) begin
      eval_act = ACT_ARM;
    end else if (armed_q && !hit && !flags_q[FLAG_LATCHED]) begin
      eval_act = ACT_FAIL;
    end else if (!armed_q) begin
      eval_act = ACT_HOLD;
    end else begin
      eval_act = ACT_COUNT;
    end

    // Time that runs backwards counts as no time gone by.
    el        = (now_q >= start_q) ? now_q - start_q : '0;
    run_ticks = down_q ? dn_q : up_q;
    el_full   = (el[TIME_BITS-1:TICK_BITS] != '0) || (el[TICK_BITS-1:0] >= run_ticks);
  end

  // ---------------------------------------------------------------------------
  // Progress divider.
  div_req_t             div_req;
  logic                 div_done;
  logic [PROG_FRAC-1:0] div_quo;
  logic                 div_start;

  assign div_req.start    = div_start;
  assign div_req.dividend = el[TICK_BITS-1:0];
  assign div_req.divisor  = run_ticks;

  wtt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // ---------------------------------------------------------------------------
  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (eval_act == ACT_COUNT && !el_full) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end else begin
          state_d = ST_COMMIT;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Commit: next trigger state and outputs.
  logic                   n_done, n_ff, n_rf, n_armed, n_halted, n_down;
  logic [PROG_BITS-1:0]   n_fp, n_rp;
  logic                   evaluate, reached, ph_go, changed;
  logic [TICK_BITS-1:0]   ph_ticks;
  logic [TIME_BITS:0]     ph_sum;
  logic [TIME_BITS-1:0]   ph_deadline;
  logic                   repeat_on;

  always_comb begin
    n_done    = o_done_q;
    n_fp      = o_fp_q;
    n_rp      = o_rp_q;
    n_ff      = o_ff_q;
    n_rf      = o_rf_q;
    n_armed   = armed_q;
    n_halted  = halted_q;
    n_down    = down_q;
    evaluate  = 1'b0;
    ph_go     = 1'b0;
    ph_ticks  = up_q;
    repeat_on = flags_q[FLAG_REPEAT];
    reached   = (now_q >= deadline_q);

    case (act_q)
      ACT_ARM: begin
        evaluate = 1'b1;
        n_done   = 1'b0;
        n_fp     = PROG_IDLE;
        n_rp     = PROG_IDLE;
        n_ff     = 1'b0;
        n_rf     = 1'b0;
        n_armed  = 1'b1;
        n_down   = (mode == CNT_DOWN);
        ph_go    = 1'b1;
        ph_ticks = (mode == CNT_DOWN) ? dn_q : up_q;
      end
      ACT_FAIL: begin
        evaluate = 1'b1;
        n_done   = 1'b0;
        n_fp     = PROG_IDLE;
        n_rp     = PROG_IDLE;
        n_ff     = !down_q;
        n_rf     = down_q;
        n_armed  = 1'b0;
      end
      ACT_COUNT: begin
        evaluate = 1'b1;
        n_ff     = 1'b0;
        n_rf     = 1'b0;
        if (!down_q) begin
          n_fp = prog_q;
          n_rp = PROG_IDLE;
          if (reached) begin
            n_done = 1'b1;
            if (mode == CNT_UP) begin
              n_halted = halted_q || !repeat_on;
              ph_go    = 1'b1;
              ph_ticks = up_q;
            end else if (mode == CNT_UP_DOWN) begin
              n_down   = 1'b1;
              ph_go    = 1'b1;
              ph_ticks = dn_q;
            end
          end
        end else begin
          n_fp = PROG_IDLE;
          n_rp = prog_q;
          if (reached) begin
            if (mode == CNT_DOWN) begin
              n_halted = halted_q || !repeat_on;
              ph_go    = 1'b1;
              ph_ticks = dn_q;
            end else if (mode == CNT_UP_DOWN) begin
              if (!repeat_on) begin
                n_halted = 1'b1;
              end else begin
                n_down = 1'b0;
              end
              ph_go    = 1'b1;
              ph_ticks = up_q;
            end
          end
        end
      end
      default: begin
        evaluate = 1'b0;
      end
    endcase

    // A deadline past the largest time saturates to it.
    ph_sum      = {1'b0, now_q} + (TIME_BITS + 1)'(ph_ticks);
    ph_deadline = ph_sum[TIME_BITS] ? '1 : ph_sum[TIME_BITS-1:0];

    changed = evaluate && (!prev_valid_q || n_done != p_done_q || n_fp != p_fp_q ||
                           n_rp != p_rp_q || n_ff != p_ff_q || n_rf != p_rf_q);
  end

  logic commit;
  assign commit = (state_q == ST_COMMIT) && out_free;

  // ---------------------------------------------------------------------------
  // Control and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q         <= '0;
      hi_q         <= '0;
      up_q         <= TICK_BITS'(1);
      dn_q         <= TICK_BITS'(1);
      cmode_q      <= CNT_UP;
      smode_q      <= SENSE_ABOVE;
      flags_q      <= '0;
      class_q      <= CLS_UNKNOWN;
      armed_q      <= 1'b0;
      halted_q     <= 1'b0;
      down_q       <= 1'b0;
      start_q      <= '0;
      deadline_q   <= '0;
      o_done_q     <= 1'b0;
      o_fp_q       <= PROG_IDLE;
      o_rp_q       <= PROG_IDLE;
      o_ff_q       <= 1'b0;
      o_rf_q       <= 1'b0;
      prev_valid_q <= 1'b0;
      act_q        <= ACT_HOLD;
      out_valid_q  <= 1'b0;
    end else begin
      if (state_q == ST_EVAL) begin
        act_q <= eval_act;
        if (class_upd) begin
          class_q <= cls;
        end
      end

      if (commit) begin
        armed_q  <= n_armed;
        halted_q <= n_halted;
        down_q   <= n_down;
        o_done_q <= n_done;
        o_fp_q   <= n_fp;
        o_rp_q   <= n_rp;
        o_ff_q   <= n_ff;
        o_rf_q   <= n_rf;
        if (ph_go) begin
          start_q    <= now_q;
          deadline_q <= ph_deadline;
        end
        if (evaluate) begin
          prev_valid_q <= 1'b1;
        end
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_fire) begin
        case (cfg_idx_e'(cfg_index_i))
          REG_LOW_THRESHOLD:  lo_q    <= cfg_data_i[SAMPLE_BITS-1:0];
          REG_HIGH_THRESHOLD: hi_q    <= cfg_data_i[SAMPLE_BITS-1:0];
          REG_UP_TICKS:       up_q    <= cfg_data_i[TICK_BITS-1:0];
          REG_DOWN_TICKS:     dn_q    <= cfg_data_i[TICK_BITS-1:0];
          REG_COUNT_MODE:     cmode_q <= cfg_data_i[MODE_BITS-1:0];
          REG_SENSE_MODE:     smode_q <= cfg_data_i[MODE_BITS-1:0];
          REG_MODE_FLAGS: begin
            flags_q <= cfg_data_i[FLAG_BITS-1:0];
            // Clearing the enable drops the timer and any stop.
            if (!cfg_data_i[FLAG_ENABLE]) begin
              armed_q  <= 1'b0;
              halted_q <= 1'b0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      smp_q <= in_data_i.sample_value;
      now_q <= in_data_i.time_now;
    end
    if (state_q == ST_EVAL) begin
      prog_q <= PROG_ONE;
    end else if (state_q == ST_DIV && div_done) begin
      prog_q <= PROG_BITS'(div_quo);
    end
    if (commit) begin
      if (evaluate) begin
        p_done_q <= n_done;
        p_fp_q   <= n_fp;
        p_rp_q   <= n_rp;
        p_ff_q   <= n_ff;
        p_rf_q   <= n_rf;
      end
      out_q.done_level       <= n_done;
      out_q.forward_progress <= n_fp;
      out_q.reverse_progress <= n_rp;
      out_q.forward_failed   <= n_ff;
      out_q.reverse_failed   <= n_rf;
      out_q.outputs_changed  <= changed;
    end
  end

endmodule

// ===== verif/wtt_checker.sv =====
// Checker for the windowed time trigger: watches the input, output and
// configuration channels, predicts each result and compares it field by field.
// Depends on wtt_pkg.
`timescale 1ns / 1ps

module wtt_checker import wtt_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  wtt_in_t                  in_data_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  wtt_out_t                 out_data_i,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  output int unsigned              mismatch_count_o,
  output int unsigned              pending_results_o
);

  localparam logic [TIME_BITS-1:0] TIME_MAX  = '1;
  localparam logic [PROG_BITS-1:0] PREV_NONE = 16'h7FFF;

  // Configuration copy.
  logic signed [SAMPLE_BITS-1:0] low_thr, high_thr;
  logic [TICK_BITS-1:0]          up_len, down_len;
  logic [MODE_BITS-1:0]          cnt_mode, sense_sel;
  logic [FLAG_BITS-1:0]          flags;

  // Trigger state.
  class_e               last_class;
  bit                   armed, halted, going_down;
  logic [TIME_BITS-1:0] start_t, deadline_t;
  logic                 held_done, held_ffail, held_rfail;
  logic [PROG_BITS-1:0] held_fwd, held_rev;
  logic [PROG_BITS-1:0] prev_vals [5];

  wtt_out_t    trigger_results_q [$];
  wtt_out_t    want;
  wtt_out_t    predicted;
  int unsigned failures;

  function automatic void begin_phase(logic [TIME_BITS-1:0] now, logic [TICK_BITS-1:0] len);
    start_t = now;
    if (TIME_BITS'(len) > TIME_MAX - now) deadline_t = TIME_MAX;
    else deadline_t = now + TIME_BITS'(len);
  endfunction

  function automatic logic [PROG_BITS-1:0] phase_progress(logic [TIME_BITS-1:0] now,
                                                          logic [TICK_BITS-1:0] len);
    logic [TIME_BITS-1:0] el;
    logic [63:0]          frac;
    el = (now >= start_t) ? now - start_t : '0;
    if (el >= TIME_BITS'(len)) return PROG_ONE;
    frac = (64'(el) << PROG_FRAC) / 64'(len);
    return frac[PROG_BITS-1:0];
  endfunction

  function automatic void set_held(logic d, logic [PROG_BITS-1:0] fp, logic [PROG_BITS-1:0] rp,
                                   logic ff, logic rf);
    held_done  = d;
    held_fwd   = fp;
    held_rev   = rp;
    held_ffail = ff;
    held_rfail = rf;
  endfunction

  // Builds the result from the held outputs; the change flag is only
  // evaluated on steps that actually ran the trigger logic.
  function automatic wtt_out_t settle(bit evaluate);
    logic [PROG_BITS-1:0] cur [5];
    wtt_out_t             r;
    cur = '{PROG_BITS'(held_done), held_fwd, held_rev, PROG_BITS'(held_ffail),
            PROG_BITS'(held_rfail)};
    r = '{held_done, held_fwd, held_rev, held_ffail, held_rfail, 1'b0};
    if (evaluate) begin
      for (int i = 0; i < 5; i++) begin
        if (cur[i] != prev_vals[i]) begin
          r.outputs_changed = 1'b1;
          prev_vals[i] = cur[i];
        end
      end
    end
    return r;
  endfunction

  function automatic wtt_out_t predict_trigger(wtt_in_t item);
    class_e               cls;
    count_mode_e          mode;
    bit                   hit, latched, repeat_on;
    logic [TIME_BITS-1:0] now;
    now       = item.time_now;
    mode      = (cnt_mode inside {CNT_DOWN, CNT_UP_DOWN}) ? count_mode_e'(cnt_mode) : CNT_UP;
    latched   = flags[FLAG_LATCHED];
    repeat_on = flags[FLAG_REPEAT];

    if (!flags[FLAG_ENABLE] || halted) return settle(1'b0);

    if ($signed(item.sample_value) < low_thr) cls = CLS_BELOW;
    else if ($signed(item.sample_value) < high_thr) cls = CLS_INSIDE;
    else cls = CLS_ABOVE;

    if (last_class == CLS_UNKNOWN) begin
      last_class = cls;
      return settle(1'b0);
    end

    hit = (sense_sel == SENSE_ABOVE  && cls == CLS_ABOVE) ||
          (sense_sel == SENSE_BELOW  && cls == CLS_BELOW) ||
          (sense_sel == SENSE_INSIDE && cls == CLS_INSIDE);
    last_class = cls;

    if (!armed && hit) begin
      armed = 1'b1;
      set_held(1'b0, PROG_IDLE, PROG_IDLE, 1'b0, 1'b0);
      going_down = (mode == CNT_DOWN);
      begin_phase(now, going_down ? down_len : up_len);
      return settle(1'b1);
    end
    if (armed && !hit && !latched) begin
      if (!going_down) set_held(1'b0, PROG_IDLE, PROG_IDLE, 1'b1, 1'b0);
      else set_held(1'b0, PROG_IDLE, PROG_IDLE, 1'b0, 1'b1);
      armed = 1'b0;
      return settle(1'b1);
    end
    if (!armed) return settle(1'b0);

    if (!going_down) begin
      set_held(held_done, phase_progress(now, up_len), PROG_IDLE, 1'b0, 1'b0);
      if (now >= deadline_t) begin
        held_done = 1'b1;
        if (mode == CNT_UP) begin
          if (!repeat_on) halted = 1'b1;
          begin_phase(now, up_len);
        end else if (mode == CNT_UP_DOWN) begin
          going_down = 1'b1;
          begin_phase(now, down_len);
        end
      end
    end else begin
      set_held(held_done, PROG_IDLE, phase_progress(now, down_len), 1'b0, 1'b0);
      if (now >= deadline_t) begin
        if (mode == CNT_DOWN) begin
          if (!repeat_on) halted = 1'b1;
          begin_phase(now, down_len);
        end else if (mode == CNT_UP_DOWN) begin
          if (!repeat_on) halted = 1'b1;
          else going_down = 1'b0;
          begin_phase(now, up_len);
        end
      end
    end
    return settle(1'b1);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_thr    = '0;
      high_thr   = '0;
      up_len     = 1;
      down_len   = 1;
      cnt_mode   = CNT_UP;
      sense_sel  = SENSE_ABOVE;
      flags      = '0;
      last_class = CLS_UNKNOWN;
      armed      = 1'b0;
      halted     = 1'b0;
      going_down = 1'b0;
      start_t    = '0;
      deadline_t = '0;
      set_held(1'b0, PROG_IDLE, PROG_IDLE, 1'b0, 1'b0);
      foreach (prev_vals[i]) prev_vals[i] = PREV_NONE;
      trigger_results_q.delete();
      failures = 0;
      mismatch_count_o  <= 0;
      pending_results_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (trigger_results_q.size() == 0) begin
          if (failures < 10)
            $display("%0t: result with nothing pending: done=%0d fwd=%0d rev=%0d ff=%0d rf=%0d ch=%0d",
                     $realtime, out_data_i.done_level, out_data_i.forward_progress,
                     out_data_i.reverse_progress, out_data_i.forward_failed,
                     out_data_i.reverse_failed, out_data_i.outputs_changed);
          failures++;
        end else begin
          want = trigger_results_q.pop_front();
          if (out_data_i.done_level !== want.done_level ||
              out_data_i.forward_progress !== want.forward_progress ||
              out_data_i.reverse_progress !== want.reverse_progress ||
              out_data_i.forward_failed !== want.forward_failed ||
              out_data_i.reverse_failed !== want.reverse_failed ||
              out_data_i.outputs_changed !== want.outputs_changed) begin
            if (failures < 10) begin
              $display("%0t: mismatch, expected done=%0d fwd=%0d rev=%0d ff=%0d rf=%0d ch=%0d",
                       $realtime, want.done_level, want.forward_progress,
                       want.reverse_progress, want.forward_failed, want.reverse_failed,
                       want.outputs_changed);
              $display("%0t:           actual done=%0d fwd=%0d rev=%0d ff=%0d rf=%0d ch=%0d",
                       $realtime, out_data_i.done_level, out_data_i.forward_progress,
                       out_data_i.reverse_progress, out_data_i.forward_failed,
                       out_data_i.reverse_failed, out_data_i.outputs_changed);
            end
            failures++;
          end
        end
      end

      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_LOW_THRESHOLD:  low_thr   = cfg_data_i[SAMPLE_BITS-1:0];
          REG_HIGH_THRESHOLD: high_thr  = cfg_data_i[SAMPLE_BITS-1:0];
          REG_UP_TICKS:       up_len    = cfg_data_i[TICK_BITS-1:0];
          REG_DOWN_TICKS:     down_len  = cfg_data_i[TICK_BITS-1:0];
          REG_COUNT_MODE:     cnt_mode  = cfg_data_i[MODE_BITS-1:0];
          REG_SENSE_MODE:     sense_sel = cfg_data_i[MODE_BITS-1:0];
          REG_MODE_FLAGS: begin
            flags = cfg_data_i[FLAG_BITS-1:0];
            // Clearing the enable drops the armed and halted state.
            if (!flags[FLAG_ENABLE]) begin
              armed  = 1'b0;
              halted = 1'b0;
            end
          end
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_i) begin
        predicted         = predict_trigger(in_data_i);
        trigger_results_q = {trigger_results_q, predicted};
      end

      mismatch_count_o  <= failures;
      pending_results_o <= trigger_results_q.size();
    end
  end

endmodule

// ===== verif/testbench.sv =====
// Top of the windowed time trigger testbench: clock, reset, stimulus on the
// input and configuration channels, random output stall, watchdog and verdict.
// Depends on wtt_pkg, windowed_time_trigger and wtt_checker.
`timescale 1ns / 1ps

module testbench;
  import wtt_pkg::*;

  localparam int unsigned             IDLE_LIMIT        = 5000;
  localparam int unsigned             ITEMS_PER_PHASE   = 400;
  localparam logic [TIME_BITS-1:0]    TIME_MAX          = '1;
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED        = 3'd7;
  localparam logic [MODE_BITS-1:0]    MODE_CODE_UNUSED  = 2'd3;
  localparam logic [MODE_BITS-1:0]    SENSE_CODE_UNUSED = 2'd3;
  localparam logic [FLAG_BITS-1:0]    EN  = FLAG_BITS'(1 << FLAG_ENABLE);
  localparam logic [FLAG_BITS-1:0]    LAT = FLAG_BITS'(1 << FLAG_LATCHED);
  localparam logic [FLAG_BITS-1:0]    REP = FLAG_BITS'(1 << FLAG_REPEAT);

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  wtt_in_t                  in_data = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  wtt_out_t                 out_data;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  int unsigned mismatch_total;
  int unsigned pending_results;
  int unsigned send_idle_pct = 37;
  int unsigned recv_idle_pct = 62;
  int unsigned idle_cycles = 0;

  // Stimulus copy of the configuration, used to steer samples and times.
  int                   thr_low, thr_high;
  logic [TICK_BITS-1:0] up_len, down_len;
  logic [MODE_BITS-1:0] sense_sel;
  logic [TIME_BITS-1:0] stim_time = '0;

  windowed_time_trigger uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  wtt_checker u_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .in_data_i         (in_data),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .out_data_i        (out_data),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_i       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .mismatch_count_o  (mismatch_total),
    .pending_results_o (pending_results)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Ends the run when no transaction of any channel completes for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_sample(logic signed [SAMPLE_BITS-1:0] s, logic [TIME_BITS-1:0] t);
    wtt_in_t item;
    item.sample_value = s;
    item.time_now     = t;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Writes every register while the block is idle, optionally clearing the
  // enable first so that the timer is disarmed.
  task automatic configure(int lo, int hi, logic [TICK_BITS-1:0] up, logic [TICK_BITS-1:0] dn,
                           logic [MODE_BITS-1:0] cm, logic [MODE_BITS-1:0] sm,
                           logic [FLAG_BITS-1:0] fl, bit clear_first);
    wait_all_results();
    repeat (2) @(posedge clk);
    if (clear_first) write_reg(REG_MODE_FLAGS, '0);
    write_reg(REG_LOW_THRESHOLD, lo);
    write_reg(REG_HIGH_THRESHOLD, hi);
    write_reg(REG_UP_TICKS, up);
    write_reg(REG_DOWN_TICKS, dn);
    write_reg(REG_COUNT_MODE, CFG_DATA_BITS'(cm));
    write_reg(REG_SENSE_MODE, CFG_DATA_BITS'(sm));
    write_reg(REG_MODE_FLAGS, CFG_DATA_BITS'(fl));
    cfg_valid <= 1'b0;
    thr_low   = lo;
    thr_high  = hi;
    up_len    = up;
    down_len  = dn;
    sense_sel = sm;
  endtask

  function automatic int pick_edge();
    case ($urandom_range(0, 9))
      0:       return -32768;
      1:       return 32767;
      default: return int'($signed(16'($urandom)));
    endcase
  endfunction

  function automatic logic [TICK_BITS-1:0] pick_ticks();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return '1;
      2:       return $urandom;
      default: return $urandom_range(1, 300);
    endcase
  endfunction

  // Random value that falls into the given class of the current window, or any value when that class is empty.
  function automatic logic signed [SAMPLE_BITS-1:0] sample_in_class(class_e c);
    int lo, hi;
    case (c)
      CLS_BELOW: begin
        lo = -32768;
        hi = thr_low - 1;
      end
      CLS_INSIDE: begin
        lo = thr_low;
        hi = thr_high - 1;
      end
      default: begin
        lo = (thr_high > thr_low) ? thr_high : thr_low;
        hi = 32767;
      end
    endcase
    if (lo > hi) return SAMPLE_BITS'($urandom);
    return SAMPLE_BITS'(lo + int'($urandom_range(0, hi - lo)));
  endfunction

  task automatic randomize_setting();
    int                   a, b, tmp;
    logic [MODE_BITS-1:0] cm, sm;
    logic [FLAG_BITS-1:0] fl;
    a = pick_edge();
    b = pick_edge();
    if (a > b && $urandom_range(0, 9) != 0) begin
      tmp = a;
      a   = b;
      b   = tmp;
    end
    cm = ($urandom_range(0, 9) == 0) ? MODE_CODE_UNUSED
                                     : MODE_BITS'($urandom_range(CNT_UP, CNT_UP_DOWN));
    sm = ($urandom_range(0, 19) == 0) ? SENSE_CODE_UNUSED
                                      : MODE_BITS'($urandom_range(SENSE_ABOVE, SENSE_INSIDE));
    fl = '0;
    fl[FLAG_ENABLE]  = ($urandom_range(0, 9) != 0);
    fl[FLAG_LATCHED] = 1'($urandom_range(0, 1));
    fl[FLAG_REPEAT]  = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 19))
      0, 1, 2, 3: stim_time = TIME_BITS'({$urandom, $urandom});
      4:          stim_time = TIME_MAX - TIME_BITS'($urandom_range(0, 1000));
      default:    ;
    endcase
    configure(a, b, pick_ticks(), pick_ticks(), cm, sm, fl, $urandom_range(0, 3) == 0);
  endtask

  // Mostly samples of the sensed class so that the timer arms and runs,
  // with other classes to break counts and some plain noise.
  task automatic send_random_item();
    class_e                        target;
    logic signed [SAMPLE_BITS-1:0] s;
    logic [TIME_BITS-1:0]          step;
    logic [TICK_BITS-1:0]          hint;
    int unsigned                   r;
    case (sense_sel)
      SENSE_ABOVE:  target = CLS_ABOVE;
      SENSE_BELOW:  target = CLS_BELOW;
      SENSE_INSIDE: target = CLS_INSIDE;
      default:      target = class_e'($urandom_range(CLS_BELOW, CLS_ABOVE));
    endcase
    r = $urandom_range(0, 99);
    if (r < 70) s = sample_in_class(target);
    else if (r < 85) s = sample_in_class(class_e'($urandom_range(CLS_BELOW, CLS_ABOVE)));
    else s = SAMPLE_BITS'($urandom);

    hint = (up_len < down_len) ? up_len : down_len;
    if (hint == 0) hint = 4;
    if (hint > 4096) hint = 4096;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      stim_time = stim_time - TIME_BITS'($urandom_range(0, 50));
    end else begin
      if (r < 13) step = TIME_BITS'($urandom);
      else step = TIME_BITS'($urandom_range(0, hint / 3 + 1));
      if (TIME_MAX - stim_time < step) stim_time = TIME_MAX;
      else stim_time = stim_time + step;
    end
    send_sample(s, stim_time);
  endtask

  initial begin
    int unsigned sent, block;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Still disabled after reset, so this one is held.
    send_sample(32767, 0);
    configure(-1000, 1000, 100, 50, CNT_UP_DOWN, SENSE_ABOVE, EN, 1'b0);
    send_sample(-32768, 10);           // first classified sample
    send_sample(0, 20);                // idle, class not selected
    send_sample(32767, 30);            // arms, up phase ends at 130
    send_sample(5000, 80);
    send_sample(5000, 70);             // time running backwards
    send_sample(2000, 130);            // up done, switch to down
    send_sample(1000, 150);            // upper edge belongs to above
    send_sample(999, 160);             // class lost in down count
    send_sample(32767, 170);
    send_sample(32767, 170);
    send_sample(32767, 170);           // no change of the outputs
    send_sample(-1, 175);              // class lost in up count
    configure(-1000, 1000, '1, '0, CNT_DOWN, SENSE_BELOW, EN | LAT | REP, 1'b0);
    send_sample(-32768, 200);          // zero-length down phase
    send_sample(0, 205);               // latched: count goes on
    send_sample(0, 210);
    configure(-1000, 1000, '1, '0, MODE_CODE_UNUSED, SENSE_INSIDE, EN | LAT, 1'b1);
    send_sample(0, TIME_MAX - 16);     // deadline saturates at the largest time
    send_sample(0, TIME_MAX);          // done, then halted
    send_sample(0, TIME_MAX);
    configure(1000, -1000, 1, 1, CNT_UP, SENSE_CODE_UNUSED, EN, 1'b1);
    write_reg(REG_UNUSED, '1);
    cfg_valid <= 1'b0;
    send_sample(500, 10);              // inverted window
    send_sample(-2000, 20);
    send_sample(32767, 30);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 37;
          recv_idle_pct = 62;
        end
        1: begin
          send_idle_pct = 62;
          recv_idle_pct = 37;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        randomize_setting();
        block = $urandom_range(20, 60);
        repeat (block) send_random_item();
        sent += block;
      end
    end

    wait_all_results();
    repeat (40) @(posedge clk);
    if (mismatch_total == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
